>>> rtl/core/irra_pkg.sv
package irra_pkg;

    // fixed widths of the ports
    localparam int PIX_W         = 32;
    localparam int CFG_SIZE_BITS = 9;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 9;

    // defaults of the top level parameters
    localparam int DEF_FRAME_COLS = 256;
    localparam int DEF_FRAME_ROWS = 256;
    localparam int DEF_PIXEL_BITS = 32;

    // register reset values
    localparam logic [CFG_SIZE_BITS-1:0] RST_WIDTH  = CFG_SIZE_BITS'(256);
    localparam logic [CFG_SIZE_BITS-1:0] RST_HEIGHT = CFG_SIZE_BITS'(256);

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROTATION = 2'd2;

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // clockwise rotation codes
    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    // controller to datapath
    typedef struct packed {
        logic size_latch;
        logic div_start;
        logic coord_load;
        logic run;
    } irra_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cfg_write;
        logic div_done;
    } irra_status_t;

endpackage

>>> rtl/core/irra_if.sv
// request channel
interface irra_in_if import irra_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output req_type, output pixel_in, input ready);
    modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

// result channel
interface irra_out_if import irra_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             last_pixel;

    modport source (output valid, output pixel_out, output last_pixel, input ready);
    modport sink   (input valid, input pixel_out, input last_pixel, output ready);
endinterface

// register write channel
interface irra_cfg_if import irra_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/irra_ram.sv
module irra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/irra_div.sv
module irra_div #(
    parameter int DIVIDEND_BITS = 16,
    parameter int DIVISOR_BITS  = 9
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     done,
    output logic [DIVIDEND_BITS-1:0] quotient,
    output logic [DIVISOR_BITS-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

    logic [CNT_W-1:0]         cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVIDEND_BITS-1:0] quo_next;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  rem_next;
    logic [DIVISOR_BITS-1:0]  div_reg;
    logic [DIVISOR_BITS:0]    shifted;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        if (shifted >= {1'b0, div_reg})
        begin
            rem_next = DIVISOR_BITS'(shifted - {1'b0, div_reg});
            quo_next = {quo_reg[DIVIDEND_BITS-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[DIVISOR_BITS-1:0];
            quo_next = {quo_reg[DIVIDEND_BITS-2:0], 1'b0};
        end
    end

    // step sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIVIDEND_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/core/irra_datapath.sv
module irra_datapath import irra_pkg::*; #(
    parameter int FRAME_COLS = DEF_FRAME_COLS,
    parameter int FRAME_ROWS = DEF_FRAME_ROWS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  irra_cmd_t     cmd,
    output irra_status_t  status,
    irra_in_if.sink       pix_in,
    irra_out_if.source    pix_out,
    irra_cfg_if.sink      cfg
);

    localparam int DEPTH = FRAME_COLS * FRAME_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int TB    = $clog2(DEPTH + 1);
    localparam int WB    = $clog2(FRAME_COLS + 1);
    localparam int HB    = $clog2(FRAME_ROWS + 1);
    localparam int GW    = (WB > HB) ? WB : HB;
    localparam int CW    = (GW > CFG_SIZE_BITS) ? GW : CFG_SIZE_BITS;
    localparam int XB    = $clog2(FRAME_COLS);
    localparam int YB    = $clog2(FRAME_ROWS);
    localparam int DB    = $clog2((FRAME_COLS > FRAME_ROWS) ? FRAME_COLS : FRAME_ROWS);
    localparam int PB    = YB + WB;
    localparam int EXT_W = PIXEL_BITS + PIX_W;

    // register bank
    logic [CFG_SIZE_BITS-1:0] cfg_w_reg;
    logic [CFG_SIZE_BITS-1:0] cfg_h_reg;
    rot_t                     cfg_rot_reg;
    logic                     cfg_fire;

    // frame geometry, latched after each register write
    logic [WB-1:0] w_reg;
    logic [GW-1:0] w_m1_reg;
    logic [GW-1:0] h_m1_reg;
    logic [GW-1:0] dw_reg;
    logic [GW-1:0] dw_m1_reg;
    logic [TB-1:0] total_reg;
    logic [TB-1:0] total_m1_reg;
    rot_t          rot_reg;
    logic [WB-1:0] w_next;
    logic [HB-1:0] h_next;
    logic [TB-1:0] total_next;
    logic [CW-1:0] cw_in;
    logic [CW-1:0] ch_in;

    // positions
    logic [AW-1:0] ld_p_reg;
    logic [AW-1:0] ld_p_next;
    logic [AW-1:0] rd_p_reg;
    logic [AW-1:0] rd_p_next;
    logic [AW-1:0] rd_p_fix;
    logic [AW-1:0] ld_p_fix;
    logic [DB-1:0] dx_reg;
    logic [DB-1:0] dx_next;
    logic [DB-1:0] dy_reg;
    logic [DB-1:0] dy_next;
    logic          is_last;

    // address generation
    logic [GW-1:0] sx;
    logic [GW-1:0] sy;
    logic [PB-1:0] row_base;
    logic [AW-1:0] rd_addr;

    // handshakes and result stage
    logic                  in_ready;
    logic                  ld_fire;
    logic                  rd_fire;
    logic                  out_valid_reg;
    logic                  last_reg;
    logic [PIXEL_BITS-1:0] wr_data;
    logic [PIXEL_BITS-1:0] rd_data;
    logic [EXT_W-1:0]      wr_ext;
    logic [EXT_W-1:0]      rd_ext;

    // divider
    logic          div_done;
    logic [AW-1:0] div_quo;
    logic [GW-1:0] div_rem;

    // register writes are always taken
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg   <= RST_WIDTH;
            cfg_h_reg   <= RST_HEIGHT;
            cfg_rot_reg <= ROT_0;
        end
        else if (cfg_fire)
        begin
            case (cfg.index)
                REG_WIDTH:    cfg_w_reg   <= cfg.data;
                REG_HEIGHT:   cfg_h_reg   <= cfg.data;
                REG_ROTATION: cfg_rot_reg <= rot_t'(cfg.data[1:0]);
                default:      ;
            endcase
        end
    end

    // size clamping: zero counts as one, oversize counts as the maximum
    always_comb
    begin
        cw_in = CW'(cfg_w_reg);
        ch_in = CW'(cfg_h_reg);
        if (cw_in == '0)
        begin
            w_next = WB'(1);
        end
        else if (cw_in > CW'(FRAME_COLS))
        begin
            w_next = WB'(FRAME_COLS);
        end
        else
        begin
            w_next = WB'(cw_in);
        end
        if (ch_in == '0)
        begin
            h_next = HB'(1);
        end
        else if (ch_in > CW'(FRAME_ROWS))
        begin
            h_next = HB'(FRAME_ROWS);
        end
        else
        begin
            h_next = HB'(ch_in);
        end
        total_next = TB'(w_next * h_next);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.size_latch)
        begin
            w_reg        <= w_next;
            w_m1_reg     <= GW'(w_next) - 1'b1;
            h_m1_reg     <= GW'(h_next) - 1'b1;
            total_reg    <= total_next;
            total_m1_reg <= total_next - 1'b1;
            rot_reg      <= cfg_rot_reg;
            if (cfg_rot_reg == ROT_90 || cfg_rot_reg == ROT_270)
            begin
                dw_reg    <= GW'(h_next);
                dw_m1_reg <= GW'(h_next) - 1'b1;
            end
            else
            begin
                dw_reg    <= GW'(w_next);
                dw_m1_reg <= GW'(w_next) - 1'b1;
            end
        end
    end

    // positions at or past the frame end fall back to zero when used
    assign ld_p_fix = (TB'(ld_p_reg) >= total_reg) ? '0 : ld_p_reg;
    assign rd_p_fix = (TB'(rd_p_reg) >= total_reg) ? '0 : rd_p_reg;

    // split the read position into destination column and row
    irra_div #(
        .DIVIDEND_BITS (AW),
        .DIVISOR_BITS  (GW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (rd_p_fix),
        .divisor   (dw_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign status.cfg_write = cfg_fire;
    assign status.div_done  = div_done;

    // input handshake: a load never waits on the result stage
    assign in_ready = cmd.run &
        (pix_in.req_type == REQ_LOAD | !out_valid_reg | pix_out.ready);
    assign pix_in.ready = in_ready;
    assign ld_fire = pix_in.valid & in_ready & (pix_in.req_type == REQ_LOAD);
    assign rd_fire = pix_in.valid & in_ready & (pix_in.req_type == REQ_READ);

    // position stepping
    always_comb
    begin
        is_last   = (TB'(rd_p_fix) == total_m1_reg);
        ld_p_next = (TB'(ld_p_fix) == total_m1_reg) ? '0 : ld_p_fix + 1'b1;
        if (is_last)
        begin
            rd_p_next = '0;
            dx_next   = '0;
            dy_next   = '0;
        end
        else if (GW'(dx_reg) == dw_m1_reg)
        begin
            rd_p_next = rd_p_fix + 1'b1;
            dx_next   = '0;
            dy_next   = dy_reg + 1'b1;
        end
        else
        begin
            rd_p_next = rd_p_fix + 1'b1;
            dx_next   = dx_reg + 1'b1;
            dy_next   = dy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_p_reg <= '0;
            rd_p_reg <= '0;
            dx_reg   <= '0;
            dy_reg   <= '0;
        end
        else
        begin
            if (ld_fire)
            begin
                ld_p_reg <= ld_p_next;
            end
            else if (rd_fire)
            begin
                rd_p_reg <= rd_p_next;
            end
            if (cmd.coord_load)
            begin
                dx_reg <= DB'(div_rem);
                dy_reg <= DB'(div_quo);
            end
            else if (rd_fire)
            begin
                dx_reg <= dx_next;
                dy_reg <= dy_next;
            end
        end
    end

    // source pixel for the current destination position
    always_comb
    begin
        case (rot_reg)
            ROT_90:
            begin
                sx = GW'(dy_reg);
                sy = h_m1_reg - GW'(dx_reg);
            end
            ROT_180:
            begin
                sx = w_m1_reg - GW'(dx_reg);
                sy = h_m1_reg - GW'(dy_reg);
            end
            ROT_270:
            begin
                sx = w_m1_reg - GW'(dy_reg);
                sy = GW'(dx_reg);
            end
            default:
            begin
                sx = GW'(dx_reg);
                sy = GW'(dy_reg);
            end
        endcase
        row_base = PB'(YB'(sy)) * PB'(w_reg);
        rd_addr  = AW'(row_base + PB'(XB'(sx)));
    end

    // pixel width conversion on the way in and out
    assign wr_ext  = {{PIXEL_BITS{1'b0}}, pix_in.pixel_in};
    assign wr_data = wr_ext[PIXEL_BITS-1:0];
    assign rd_ext  = {{PIX_W{1'b0}}, rd_data};

    irra_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (ld_fire),
        .wr_addr (ld_p_fix),
        .wr_data (wr_data),
        .rd_en   (rd_fire),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result stage: memory read register plus valid and frame-end flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else if (rd_fire)
        begin
            out_valid_reg <= 1'b1;
            last_reg      <= is_last;
        end
        else if (pix_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.pixel_out  = rd_ext[PIX_W-1:0];
    assign pix_out.last_pixel = last_reg;

    // read position stays inside the frame after a read transfer
    a_rd_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        rd_fire |=> (TB'(rd_p_reg) < total_reg))
        else $error("read position past frame end");

    // destination column stays inside the destination row
    a_dx_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run |-> (GW'(dx_reg) < dw_reg))
        else $error("destination column past row end");

    // a pending result is never overwritten by a new read
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        rd_fire |-> (!out_valid_reg || pix_out.ready))
        else $error("read taken over a pending result");

    // the frame-end result leaves the read position at zero
    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (rd_p_reg == '0))
        else $error("read position not wrapped after frame end");

endmodule

>>> rtl/core/irra_ctrl.sv
module irra_ctrl import irra_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  irra_status_t status,
    output irra_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_SIZE,
        S_WRAP,
        S_DIV,
        S_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   run_reg;

    // a register write always restarts the sizing pass
    always_comb
    begin
        state_next = state_reg;
        if (status.cfg_write)
        begin
            state_next = S_SIZE;
        end
        else
        begin
            case (state_reg)
                S_SIZE:  state_next = S_WRAP;
                S_WRAP:  state_next = S_DIV;
                S_DIV:   state_next = status.div_done ? S_RUN : S_DIV;
                S_RUN:   state_next = S_RUN;
                default: state_next = S_SIZE;
            endcase
        end
    end

    // state and registered run enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SIZE;
            run_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= (state_next == S_RUN);
        end
    end

    // command decode
    assign cmd.size_latch = (state_reg == S_SIZE);
    assign cmd.div_start  = (state_reg == S_WRAP);
    assign cmd.coord_load = (state_reg == S_DIV) & status.div_done;
    assign cmd.run        = run_reg;

endmodule

>>> rtl/core/image_rotate_right_angle.sv
// channel   dir   handshake      payload
// pix_in    in    valid/ready    req_type, pixel_in
// pix_out   out   valid/ready    pixel_out, last_pixel
// cfg       in    valid/ready    index, data (always ready)
//
// loads and reads are taken one per cycle while pix_in.ready is high; a read result
// appears in the cycle after its transfer, out of the frame store's registered read port
// a load is taken while a result waits; a read waits until it is taken
// after reset and after every register write a sizing pass runs with pix_in.ready
// low: it latches the frame size, starts the bit-serial divider that splits the
// read position, loads the destination column and row, then enables the run
// reset clears both positions, restores the registers and starts that pass
module image_rotate_right_angle import irra_pkg::*; #(
    parameter int FRAME_COLS = DEF_FRAME_COLS,
    parameter int FRAME_ROWS = DEF_FRAME_ROWS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    irra_in_if.sink    pix_in,
    irra_out_if.source pix_out,
    irra_cfg_if.sink   cfg
);

    irra_cmd_t    cmd;
    irra_status_t status;

    // sequencing of sizing pass and run
    irra_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // frame store, position counters and address generation
    irra_datapath #(
        .FRAME_COLS (FRAME_COLS),
        .FRAME_ROWS (FRAME_ROWS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .cfg     (cfg)
    );

endmodule
